### hdl/sla_pkg.sv
// Shared types and constants for the surface Laplacian applier.
// Depends on nothing; imported by sla_front, sla_div, sla_back, the top level and the testbench.
package sla_pkg;

    localparam int ACC_W   = 112;
    localparam int TOT_W   = 72;
    localparam int DIV_W   = 96;
    localparam int DIVR_W  = 32;
    localparam int Y_SHIFT = 48;

    localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
    localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MIN = 32'h8000_0000;

    localparam logic [0:0] CFG_CHANNEL_COUNT = 1'b0;
    localparam logic [0:0] CFG_INVERSE_SUM   = 1'b1;

    typedef enum logic [1:0] {
        REQ_LOAD_INV = 2'd0,
        REQ_LOAD_H   = 2'd1,
        REQ_LOAD_CS  = 2'd2,
        REQ_SAMPLE   = 2'd3
    } req_t;

    typedef struct packed {
        req_t        kind;
        logic [5:0]  row;
        logic [5:0]  col;
        logic [31:0] value;
        logic        last_sample;
    } cmd_t;

    typedef struct packed {
        logic [5:0]  channel;
        logic [31:0] laplacian;
        logic        overflow;
        logic        last;
    } out_item_t;

endpackage

### hdl/sla_queue.sv
// Small synchronous FIFO used between the front and back parts and on the result side.
// Depends on nothing; DEPTH must be a power of two.
module sla_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == (PTR_W+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = data_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### hdl/sla_front.sv
// Front part: takes input items, drops out-of-range ones and marks the final sample.
// Depends on sla_pkg.
module sla_front #(
    parameter int MAX_CHANNELS = 64,
    localparam int IDX_W = $clog2(MAX_CHANNELS)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        req_type,
    input  logic [5:0]        entry_row,
    input  logic [5:0]        entry_col,
    input  logic [31:0]       value,
    input  logic [IDX_W-1:0]  nm1,
    input  logic              cq_full,
    output logic              cq_push,
    output sla_pkg::cmd_t     cq_item
);
    import sla_pkg::*;

    req_t kind;
    logic row_ok;
    logic col_ok;
    logic keep;
    logic is_last;
    logic take;
    logic f_v_reg;
    cmd_t f_item_reg;

    assign kind    = req_t'(req_type);
    assign row_ok  = 32'(entry_row) < MAX_CHANNELS;
    assign col_ok  = 32'(entry_col) < MAX_CHANNELS;
    assign is_last = (kind == REQ_SAMPLE) && (32'(entry_col) == 32'(nm1));
    assign full    = f_v_reg && cq_full;
    assign take    = push && !full;
    assign cq_push = f_v_reg && !cq_full;
    assign cq_item = f_item_reg;

    always_comb
    begin
        case (kind)
            REQ_SAMPLE: keep = 32'(entry_col) <= 32'(nm1);
            default:    keep = row_ok && col_ok;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (!full)
        begin
            f_item_reg <= '{kind: kind, row: entry_row, col: entry_col,
                            value: value, last_sample: is_last};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_v_reg <= 1'b0;
        end
        else if (!full)
        begin
            f_v_reg <= take && keep;
        end
    end

endmodule

### hdl/sla_div.sv
// Restoring divider, one quotient bit per cycle, for the centering term.
// Depends on sla_pkg.
module sla_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [sla_pkg::DIV_W-1:0] dividend,
    input  logic [sla_pkg::DIVR_W-1:0] divisor,
    output logic                      done,
    output logic [sla_pkg::DIV_W-1:0] quotient
);
    import sla_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic [DIV_W-1:0]  dq_reg;
    logic [DIVR_W-1:0] rem_reg;
    logic [DIVR_W-1:0] dvr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIVR_W:0]   trial;
    logic              ge;
    logic [DIVR_W-1:0] rem_next;

    assign trial    = {rem_reg, dq_reg[DIV_W-1]};
    assign ge       = trial >= {1'b0, dvr_reg};
    assign rem_next = ge ? DIVR_W'(trial - {1'b0, dvr_reg}) : trial[DIVR_W-1:0];
    assign done     = done_reg;
    assign quotient = dq_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            dvr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dq_reg  <= {dq_reg[DIV_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == CNT_W'(DIV_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

endmodule

### hdl/sla_back.sv
// Back part: coefficient memories, shared multiply-accumulate pipeline and the sequencer
// that forms d, the centered vector and the outputs. Depends on sla_pkg and sla_div.
module sla_back #(
    parameter int MAX_CHANNELS = 64,
    parameter int COEF_WIDTH   = 32,
    parameter int SAMPLE_WIDTH = 24,
    localparam int IDX_W = $clog2(MAX_CHANNELS)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [IDX_W-1:0]    nm1,
    input  logic [31:0]         inverse_sum,
    input  logic                cq_empty,
    input  sla_pkg::cmd_t       cq_item,
    output logic                cq_pop,
    input  logic                oq_full,
    output logic                oq_push,
    output sla_pkg::out_item_t  oq_item
);
    import sla_pkg::*;

    localparam int CW        = (COEF_WIDTH < 32) ? COEF_WIDTH : 32;
    localparam int SW        = (SAMPLE_WIDTH < 32) ? SAMPLE_WIDTH : 32;
    localparam int VEC_DEPTH = 1 << IDX_W;
    localparam int MAT_DEPTH = 1 << (2 * IDX_W);
    localparam int YW        = ACC_W - Y_SHIFT;

    typedef enum logic [3:0] {
        S_IDLE, S_D_ISSUE, S_D_WAIT, S_TOT, S_C_RD, S_C_MUL, S_C_WAIT,
        S_C_DIV, S_C_WR, S_Y_ISSUE, S_Y_WAIT, S_Y_PUSH
    } state_t;

    typedef enum logic [1:0] {
        MODE_D, MODE_C, MODE_Y
    } mode_t;

    state_t state_reg;
    logic [IDX_W-1:0] j_reg;
    logic [IDX_W-1:0] k_reg;
    logic             part_reg;
    logic             tp_ovf_reg;
    logic signed [TOT_W-1:0] tot_acc_reg;
    logic [63:0]      tot_mag_reg;
    logic             tot_neg_reg;
    logic [63:0]      term_reg;
    out_item_t        out_reg;

    logic [CW-1:0] inv_mem [MAT_DEPTH];
    logic [CW-1:0] h_mem   [MAT_DEPTH];
    logic [CW-1:0] cs_mem  [VEC_DEPTH];
    logic [SW-1:0] smp_mem [VEC_DEPTH];
    logic [63:0]   vec_mem [VEC_DEPTH];
    logic [CW-1:0] inv_q_reg;
    logic [CW-1:0] h_q_reg;
    logic [CW-1:0] cs_q_reg;
    logic [SW-1:0] smp_q_reg;
    logic [63:0]   vec_q_reg;

    logic [2*IDX_W-1:0] mat_raddr;
    logic [2*IDX_W-1:0] mat_waddr;
    logic [IDX_W-1:0]   vec_raddr;
    logic [IDX_W-1:0]   wcol;
    logic               vec_we;
    logic [63:0]        vec_wdata;

    logic  iss_v;
    logic  iss_last;
    logic  iss_hi;
    mode_t iss_mode;
    logic  s1_v_reg;
    logic  s1_last_reg;
    logic  s1_hi_reg;
    mode_t s1_mode_reg;
    logic  s2_v_reg;
    logic  s2_last_reg;
    logic  s2_hi_reg;
    logic signed [32:0] op_a;
    logic signed [32:0] op_b;
    logic signed [65:0] p2_reg;
    logic signed [ACC_W-1:0] p_ext;
    logic signed [ACC_W-1:0] acc_sum;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] res_reg;
    logic                    res_v_reg;

    logic signed [63:0] d_val;
    logic               d_sat;
    logic signed [63:0] tot_val;
    logic               tot_sat;
    logic [63:0]        tot_mag;
    logic [31:0]        cs_s;
    logic [31:0]        cs_mag;
    logic               cs_neg;
    logic [31:0]        isum_mag;
    logic               isum_zero;
    logic               div_start;
    logic               div_done;
    logic [DIV_W-1:0]   div_quo;
    logic               q_big;
    logic [63:0]        m_val;
    logic [63:0]        term_val;
    logic [64:0]        diff;
    logic               c_sat;
    logic [63:0]        c_val;
    logic [YW-1:0]      y_wide;
    logic               y_sat;
    logic [31:0]        y_val;

    assign wcol      = IDX_W'(cq_item.col);
    assign mat_waddr = {IDX_W'(cq_item.row), wcol};
    assign mat_raddr = {k_reg, j_reg};
    assign vec_raddr = (state_reg == S_Y_ISSUE) ? k_reg : j_reg;
    assign cq_pop    = (state_reg == S_IDLE) && !cq_empty;
    assign oq_push   = (state_reg == S_Y_PUSH) && !oq_full;
    assign oq_item   = out_reg;
    assign div_start = (state_reg == S_C_WAIT) && res_v_reg;

    always_ff @(posedge clk)
    begin
        if (cq_pop && cq_item.kind == REQ_LOAD_INV)
        begin
            inv_mem[mat_waddr] <= cq_item.value[CW-1:0];
        end
        inv_q_reg <= inv_mem[mat_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cq_pop && cq_item.kind == REQ_LOAD_H)
        begin
            h_mem[mat_waddr] <= cq_item.value[CW-1:0];
        end
        h_q_reg <= h_mem[mat_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cq_pop && cq_item.kind == REQ_LOAD_CS)
        begin
            cs_mem[wcol] <= cq_item.value[CW-1:0];
        end
        cs_q_reg <= cs_mem[j_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cq_pop && cq_item.kind == REQ_SAMPLE)
        begin
            smp_mem[wcol] <= cq_item.value[SW-1:0];
        end
        smp_q_reg <= smp_mem[k_reg];
    end

    always_ff @(posedge clk)
    begin
        if (vec_we)
        begin
            vec_mem[j_reg] <= vec_wdata;
        end
        vec_q_reg <= vec_mem[vec_raddr];
    end

    always_comb
    begin
        iss_v    = 1'b0;
        iss_last = 1'b0;
        iss_hi   = part_reg;
        iss_mode = MODE_D;
        case (state_reg)
            S_D_ISSUE:
            begin
                iss_v    = 1'b1;
                iss_last = (k_reg == nm1);
                iss_hi   = 1'b0;
            end
            S_C_MUL:
            begin
                iss_v    = 1'b1;
                iss_last = part_reg;
                iss_mode = MODE_C;
            end
            S_Y_ISSUE:
            begin
                iss_v    = 1'b1;
                iss_last = (k_reg == nm1) && part_reg;
                iss_mode = MODE_Y;
            end
            default:
            begin
                iss_v = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        case (s1_mode_reg)
            MODE_C:
            begin
                op_a = s1_hi_reg ? {1'b0, tot_mag_reg[63:32]} : {1'b0, tot_mag_reg[31:0]};
                op_b = {1'b0, cs_mag};
            end
            MODE_Y:
            begin
                op_a = s1_hi_reg ? 33'($signed(vec_q_reg[63:32])) : {1'b0, vec_q_reg[31:0]};
                op_b = 33'($signed(h_q_reg));
            end
            default:
            begin
                op_a = 33'($signed(smp_q_reg));
                op_b = 33'($signed(inv_q_reg));
            end
        endcase
    end

    assign p_ext   = ACC_W'(p2_reg);
    assign acc_sum = acc_reg + (s2_hi_reg ? (p_ext <<< 32) : p_ext);

    always_ff @(posedge clk)
    begin
        s1_last_reg <= iss_last;
        s1_hi_reg   <= iss_hi;
        s1_mode_reg <= iss_mode;
        s2_last_reg <= s1_last_reg;
        s2_hi_reg   <= s1_hi_reg;
        p2_reg      <= op_a * op_b;
        if (s2_v_reg && s2_last_reg)
        begin
            res_reg <= acc_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            res_v_reg <= 1'b0;
            acc_reg   <= '0;
        end
        else
        begin
            s1_v_reg  <= iss_v;
            s2_v_reg  <= s1_v_reg;
            res_v_reg <= s2_v_reg && s2_last_reg;
            if (s2_v_reg)
            begin
                acc_reg <= s2_last_reg ? '0 : acc_sum;
            end
        end
    end

    always_comb
    begin
        d_sat = !((res_reg[ACC_W-1:63] == '0) || (res_reg[ACC_W-1:63] == '1));
        if (!d_sat)
        begin
            d_val = res_reg[63:0];
        end
        else
        begin
            d_val = res_reg[ACC_W-1] ? S64_MIN : S64_MAX;
        end

        tot_sat = !((tot_acc_reg[TOT_W-1:63] == '0) || (tot_acc_reg[TOT_W-1:63] == '1));
        if (!tot_sat)
        begin
            tot_val = tot_acc_reg[63:0];
        end
        else
        begin
            tot_val = tot_acc_reg[TOT_W-1] ? S64_MIN : S64_MAX;
        end
        tot_mag = tot_val[63] ? (64'd0 - tot_val) : tot_val;

        cs_s      = 32'($signed(cs_q_reg));
        cs_neg    = cs_s[31];
        cs_mag    = cs_neg ? (32'd0 - cs_s) : cs_s;
        isum_zero = (inverse_sum == '0);
        isum_mag  = inverse_sum[31] ? (32'd0 - inverse_sum) : inverse_sum;

        q_big    = |div_quo[DIV_W-1:63];
        m_val    = q_big ? S64_MAX : {1'b0, div_quo[62:0]};
        term_val = (tot_neg_reg ^ cs_neg) ? (64'd0 - m_val) : m_val;

        diff  = {vec_q_reg[63], vec_q_reg} - {term_reg[63], term_reg};
        c_sat = diff[64] != diff[63];
        if (!c_sat)
        begin
            c_val = diff[63:0];
        end
        else
        begin
            c_val = diff[64] ? S64_MIN : S64_MAX;
        end

        y_wide = res_reg[ACC_W-1:Y_SHIFT];
        y_sat  = !((y_wide[YW-1:31] == '0) || (y_wide[YW-1:31] == '1));
        if (!y_sat)
        begin
            y_val = y_wide[31:0];
        end
        else
        begin
            y_val = y_wide[YW-1] ? S32_MIN : S32_MAX;
        end

        vec_we    = ((state_reg == S_D_WAIT) && res_v_reg) || (state_reg == S_C_WR);
        vec_wdata = (state_reg == S_C_WR) ? c_val : d_val;
    end

    sla_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (res_reg[DIV_W-1:0]),
        .divisor  (isum_mag),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            j_reg       <= '0;
            k_reg       <= '0;
            part_reg    <= 1'b0;
            tp_ovf_reg  <= 1'b0;
            tot_acc_reg <= '0;
            tot_mag_reg <= '0;
            tot_neg_reg <= 1'b0;
            term_reg    <= '0;
            out_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (!cq_empty && cq_item.kind == REQ_SAMPLE && cq_item.last_sample)
                    begin
                        tp_ovf_reg  <= isum_zero;
                        tot_acc_reg <= '0;
                        j_reg       <= '0;
                        k_reg       <= '0;
                        state_reg   <= S_D_ISSUE;
                    end
                end
                S_D_ISSUE:
                begin
                    if (k_reg == nm1)
                    begin
                        k_reg     <= '0;
                        state_reg <= S_D_WAIT;
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                S_D_WAIT:
                begin
                    if (res_v_reg)
                    begin
                        tot_acc_reg <= tot_acc_reg + TOT_W'(d_val);
                        tp_ovf_reg  <= tp_ovf_reg | d_sat;
                        if (j_reg == nm1)
                        begin
                            j_reg     <= '0;
                            state_reg <= S_TOT;
                        end
                        else
                        begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= S_D_ISSUE;
                        end
                    end
                end
                S_TOT:
                begin
                    tot_mag_reg <= tot_mag;
                    tot_neg_reg <= tot_val[63];
                    tp_ovf_reg  <= tp_ovf_reg | tot_sat;
                    state_reg   <= S_C_RD;
                end
                S_C_RD:
                begin
                    part_reg <= 1'b0;
                    if (isum_zero)
                    begin
                        term_reg  <= '0;
                        state_reg <= S_C_WR;
                    end
                    else
                    begin
                        state_reg <= S_C_MUL;
                    end
                end
                S_C_MUL:
                begin
                    if (part_reg)
                    begin
                        part_reg  <= 1'b0;
                        state_reg <= S_C_WAIT;
                    end
                    else
                    begin
                        part_reg <= 1'b1;
                    end
                end
                S_C_WAIT:
                begin
                    if (res_v_reg)
                    begin
                        state_reg <= S_C_DIV;
                    end
                end
                S_C_DIV:
                begin
                    if (div_done)
                    begin
                        term_reg   <= term_val;
                        tp_ovf_reg <= tp_ovf_reg | q_big;
                        state_reg  <= S_C_WR;
                    end
                end
                S_C_WR:
                begin
                    tp_ovf_reg <= tp_ovf_reg | c_sat;
                    if (j_reg == nm1)
                    begin
                        j_reg     <= '0;
                        k_reg     <= '0;
                        part_reg  <= 1'b0;
                        state_reg <= S_Y_ISSUE;
                    end
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_C_RD;
                    end
                end
                S_Y_ISSUE:
                begin
                    if (part_reg)
                    begin
                        part_reg <= 1'b0;
                        if (k_reg == nm1)
                        begin
                            k_reg     <= '0;
                            state_reg <= S_Y_WAIT;
                        end
                        else
                        begin
                            k_reg <= k_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        part_reg <= 1'b1;
                    end
                end
                S_Y_WAIT:
                begin
                    if (res_v_reg)
                    begin
                        out_reg   <= '{channel: 6'(j_reg), laplacian: y_val,
                                       overflow: tp_ovf_reg | y_sat,
                                       last: (j_reg == nm1)};
                        state_reg <= S_Y_PUSH;
                    end
                end
                S_Y_PUSH:
                begin
                    if (!oq_full)
                    begin
                        if (j_reg == nm1)
                        begin
                            j_reg     <= '0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= S_Y_ISSUE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // A finished sum only ever lands while the sequencer waits for it.
    a_res_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        res_v_reg |-> (state_reg == S_D_WAIT || state_reg == S_C_WAIT ||
                       state_reg == S_Y_WAIT))
        else $error("accumulator result outside a wait state");

    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (!s1_v_reg && !s2_v_reg && acc_reg == '0))
        else $error("multiply pipeline not drained in idle");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_C_DIV))
        else $error("divider finished outside the divide state");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (j_reg <= nm1 && k_reg <= nm1))
        else $error("channel index beyond the active count");

endmodule

### hdl/surface_laplacian_apply.sv
// Top level of the spherical-spline surface Laplacian applier.
// Depends on sla_pkg, sla_queue, sla_front and sla_back.

// Load items and non-final samples pass through a short command queue. The final sample
// of a time point starts the computation, which runs on one shared 33x33 multiplier
// pipeline and a one-bit-per-cycle divider: it forms d = x*invG, then the centered vector
// with a 96-bit divide per channel (skipped when inverse_sum is zero), then y = c*H.
// Items keep queuing during the computation until the command queue fills; results wait
// in a two-entry output queue.
module surface_laplacian_apply #(
    parameter int MAX_CHANNELS = 64,
    parameter int COEF_WIDTH   = 32,
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  req_type,
    input  logic [5:0]  entry_row,
    input  logic [5:0]  entry_col,
    input  logic [31:0] value,
    output logic        empty,
    input  logic        pop,
    output logic [5:0]  channel,
    output logic [31:0] laplacian,
    output logic        overflow,
    output logic        last,
    input  logic        cfg_write,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import sla_pkg::*;

    localparam int IDX_W    = $clog2(MAX_CHANNELS);
    localparam int CH_LIMIT = (MAX_CHANNELS < 64) ? MAX_CHANNELS : 64;

    logic [6:0]       channel_count_reg;
    logic [31:0]      inverse_sum_reg;
    logic [6:0]       n_active;
    logic [IDX_W-1:0] nm1;
    logic             cq_full;
    logic             cq_push;
    logic             cq_empty;
    logic             cq_pop;
    cmd_t             cq_din;
    cmd_t             cq_dout;
    logic             oq_full;
    logic             oq_push;
    out_item_t        oq_din;
    out_item_t        oq_dout;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg <= 7'd64;
            inverse_sum_reg   <= 32'd16777216;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_CHANNEL_COUNT: channel_count_reg <= cfg_data[6:0];
                CFG_INVERSE_SUM:   inverse_sum_reg   <= cfg_data;
                default:           channel_count_reg <= channel_count_reg;
            endcase
        end
    end

    always_comb
    begin
        if (channel_count_reg < 7'd2)
        begin
            n_active = 7'd2;
        end
        else if (32'(channel_count_reg) > CH_LIMIT)
        begin
            n_active = 7'(CH_LIMIT);
        end
        else
        begin
            n_active = channel_count_reg;
        end
        nm1 = IDX_W'(n_active - 7'd1);
    end

    sla_front #(.MAX_CHANNELS(MAX_CHANNELS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req_type  (req_type),
        .entry_row (entry_row),
        .entry_col (entry_col),
        .value     (value),
        .nm1       (nm1),
        .cq_full   (cq_full),
        .cq_push   (cq_push),
        .cq_item   (cq_din)
    );

    sla_queue #(.WIDTH($bits(cmd_t)), .DEPTH(4)) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cq_push),
        .din   (cq_din),
        .full  (cq_full),
        .pop   (cq_pop),
        .dout  (cq_dout),
        .empty (cq_empty)
    );

    sla_back #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .COEF_WIDTH   (COEF_WIDTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .nm1         (nm1),
        .inverse_sum (inverse_sum_reg),
        .cq_empty    (cq_empty),
        .cq_item     (cq_dout),
        .cq_pop      (cq_pop),
        .oq_full     (oq_full),
        .oq_push     (oq_push),
        .oq_item     (oq_din)
    );

    sla_queue #(.WIDTH($bits(out_item_t)), .DEPTH(2)) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (oq_push),
        .din   (oq_din),
        .full  (oq_full),
        .pop   (pop),
        .dout  (oq_dout),
        .empty (empty)
    );

    assign channel   = oq_dout.channel;
    assign laplacian = oq_dout.laplacian;
    assign overflow  = oq_dout.overflow;
    assign last      = oq_dout.last;

endmodule

### bench/tb_surface_laplacian_apply.sv
`timescale 1ns / 1ps
// Self-checking testbench for surface_laplacian_apply: loads the matrices, streams time points
// and compares every Laplacian output with a predictor held in a scoreboard class.
// Depends on sla_pkg and the surface_laplacian_apply RTL.
module tb_surface_laplacian_apply;
    import sla_pkg::*;

    localparam int NCH = 64;
    localparam int STALL_LIMIT = 100000;
    localparam int SETTLE_CYCLES = 300;

    class laplacian_scoreboard;
        logic signed [31:0] inv_g [NCH*NCH];
        logic signed [31:0] surf_h [NCH*NCH];
        logic signed [31:0] col_sum [NCH];
        logic signed [31:0] samples [NCH];
        logic [6:0] chan_reg;
        logic signed [31:0] inv_sum;
        out_item_t expected_q[$];
        int errors;
        int results_seen;
        int points_done;

        function new();
            chan_reg = 7'd64;
            inv_sum = 32'sd16777216;
            errors = 0;
            results_seen = 0;
            points_done = 0;
        endfunction

        function int active_n();
            if (chan_reg < 2) return 2;
            if (chan_reg > NCH) return NCH;
            return chan_reg;
        endfunction

        function void set_config(logic [0:0] idx, logic [31:0] data);
            if (idx == CFG_CHANNEL_COUNT) chan_reg = data[6:0];
            else inv_sum = data;
        endfunction

        function logic signed [63:0] clip64(logic signed [127:0] x, inout bit flag);
            if (x > $signed({64'd0, S64_MAX})) begin
                flag = 1'b1;
                return S64_MAX;
            end
            if (x < -$signed({64'd0, S64_MAX}) - 1) begin
                flag = 1'b1;
                return S64_MIN;
            end
            return x[63:0];
        endfunction

        function logic [127:0] mag(logic signed [127:0] x);
            return (x < 0) ? -x : x;
        endfunction

        function void apply_point();
            logic signed [63:0] dvec [NCH];
            logic signed [63:0] cvec [NCH];
            logic signed [127:0] acc, a, b, ysh;
            logic signed [63:0] total, term;
            logic [127:0] q;
            bit tp_flag, flag;
            int n;
            out_item_t item;
            n = active_n();
            tp_flag = (inv_sum == 0);
            for (int j = 0; j < n; j++) begin
                acc = 0;
                for (int k = 0; k < n; k++) begin
                    a = samples[k];
                    b = inv_g[k*NCH+j];
                    acc += a * b;
                end
                dvec[j] = clip64(acc, tp_flag);
            end
            acc = 0;
            for (int j = 0; j < n; j++) begin
                a = dvec[j];
                acc += a;
            end
            total = clip64(acc, tp_flag);
            for (int j = 0; j < n; j++) begin
                term = 0;
                if (inv_sum != 0) begin
                    a = total;
                    b = col_sum[j];
                    q = (mag(a) * mag(b)) / mag(128'(inv_sum));
                    if (q > {64'd0, S64_MAX}) begin
                        q = {64'd0, S64_MAX};
                        tp_flag = 1'b1;
                    end
                    term = ((total < 0) != (col_sum[j] < 0)) ? -$signed(q[63:0])
                                                              : $signed(q[63:0]);
                end
                a = dvec[j];
                b = term;
                cvec[j] = clip64(a - b, tp_flag);
            end
            for (int j = 0; j < n; j++) begin
                flag = tp_flag;
                acc = 0;
                for (int k = 0; k < n; k++) begin
                    a = cvec[k];
                    b = surf_h[k*NCH+j];
                    acc += a * b;
                end
                ysh = acc >>> Y_SHIFT;
                item.channel = j[5:0];
                if (ysh > $signed({96'd0, S32_MAX})) begin
                    item.laplacian = S32_MAX;
                    flag = 1'b1;
                end else if (ysh < -$signed({96'd0, S32_MAX}) - 1) begin
                    item.laplacian = S32_MIN;
                    flag = 1'b1;
                end else begin
                    item.laplacian = ysh[31:0];
                end
                item.overflow = flag;
                item.last = (j == n - 1);
                expected_q.insert(expected_q.size(), item);
            end
            points_done++;
        endfunction

        function void note_input(req_t kind, logic [5:0] row, logic [5:0] col,
                                 logic [31:0] data);
            case (kind)
                REQ_LOAD_INV: inv_g[row*NCH+col] = data;
                REQ_LOAD_H:   surf_h[row*NCH+col] = data;
                REQ_LOAD_CS:  col_sum[col] = data;
                default: begin
                    if (col < active_n()) begin
                        samples[col] = $signed(data[23:0]);
                        if (col == active_n() - 1) apply_point();
                    end
                end
            endcase
        endfunction

        task report(string what);
            $display("%0t MISMATCH: %s", $realtime, what);
            errors++;
        endtask

        task check_result(out_item_t got);
            out_item_t want;
            results_seen++;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result ch=%0d", got.channel));
                return;
            end
            want = expected_q.pop_front();
            if (got.channel !== want.channel)
                report($sformatf("channel %0d, want %0d", got.channel, want.channel));
            if (got.laplacian !== want.laplacian)
                report($sformatf("ch %0d laplacian %h, want %h", want.channel,
                                 got.laplacian, want.laplacian));
            if (got.overflow !== want.overflow)
                report($sformatf("ch %0d overflow %b, want %b", want.channel,
                                 got.overflow, want.overflow));
            if (got.last !== want.last)
                report($sformatf("ch %0d last %b, want %b", want.channel, got.last, want.last));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    logic [1:0] req_type;
    logic [5:0] entry_row;
    logic [5:0] entry_col;
    logic [31:0] value;
    logic empty;
    logic pop;
    logic [5:0] channel;
    logic [31:0] laplacian;
    logic overflow;
    logic last;
    logic cfg_write;
    logic [0:0] cfg_index;
    logic [31:0] cfg_data;

    laplacian_scoreboard sb;
    int in_idle_pct;
    int out_idle_pct;
    int accepted;
    int stall_cycles;

    surface_laplacian_apply dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .req_type(req_type), .entry_row(entry_row), .entry_col(entry_col), .value(value),
        .empty(empty), .pop(pop), .channel(channel), .laplacian(laplacian),
        .overflow(overflow), .last(last),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        if (rst_n && push && !full)
        begin
            sb.note_input(req_t'(req_type), entry_row, entry_col, value);
            accepted++;
        end
        if (rst_n && pop && !empty)
            sb.check_result('{channel, laplacian, overflow, last});
        if ((push && !full) || (pop && !empty) || cfg_write)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog expired with %0d results outstanding", sb.expected_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(negedge clk)
        pop <= ($urandom_range(99) >= out_idle_pct);

    function logic [31:0] rand_coef();
        if ($urandom_range(3) == 0) return $urandom;
        return $urandom_range(33554432) - 32'd16777216;
    endfunction

    function int clamp_n(int raw);
        if (raw < 2) return 2;
        if (raw > NCH) return NCH;
        return raw;
    endfunction

    task send(req_t kind, logic [5:0] row, logic [5:0] col, logic [31:0] data);
        @(negedge clk);
        while ($urandom_range(99) < in_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        req_type <= kind;
        entry_row <= row;
        entry_col <= col;
        value <= data;
        do @(posedge clk); while (full);
    endtask

    task drain();
        @(negedge clk);
        push <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task write_reg(logic [0:0] idx, logic [31:0] data);
        drain();
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        sb.set_config(idx, data);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task load_region(int n);
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
            begin
                send(REQ_LOAD_INV, 6'(r), 6'(c), rand_coef());
                send(REQ_LOAD_H, 6'(r), 6'(c), rand_coef());
            end
        for (int c = 0; c < n; c++)
            send(REQ_LOAD_CS, 6'($urandom), 6'(c), rand_coef());
    endtask

    task time_point(int n, bit noisy);
        int order[$];
        for (int c = 0; c < n - 1; c++) order.insert(order.size(), c);
        order.shuffle();
        foreach (order[i])
        begin
            send(REQ_SAMPLE, 6'($urandom), 6'(order[i]), $urandom);
            if (noisy && $urandom_range(4) == 0)
            begin
                case ($urandom_range(2))
                    0: if (n < NCH) send(REQ_SAMPLE, 6'($urandom),
                                         6'($urandom_range(NCH - 1, n)), $urandom);
                    1: send(REQ_SAMPLE, 6'($urandom), 6'($urandom_range(n - 2)), $urandom);
                    default: send(REQ_LOAD_CS, 6'($urandom), 6'($urandom_range(n - 1)),
                                  rand_coef());
                endcase
            end
        end
        send(REQ_SAMPLE, 6'($urandom), 6'(n - 1), $urandom);
    endtask

    initial
    begin
        int n, raw, phases;
        sb = new();
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        req_type = REQ_LOAD_INV;
        entry_row = '0;
        entry_col = '0;
        value = '0;
        cfg_write = 1'b0;
        cfg_index = CFG_CHANNEL_COUNT;
        cfg_data = '0;
        in_idle_pct = 29;
        out_idle_pct = 29;
        accepted = 0;
        stall_cycles = 0;
        phases = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_reg(CFG_CHANNEL_COUNT, 32'd0);
        write_reg(CFG_INVERSE_SUM, 32'd16777216);
        send(REQ_LOAD_INV, 6'd0, 6'd0, 32'h7FFF_FFFF);
        send(REQ_LOAD_INV, 6'd0, 6'd1, 32'h8000_0000);
        send(REQ_LOAD_INV, 6'd1, 6'd0, 32'h0100_0000);
        send(REQ_LOAD_INV, 6'd1, 6'd1, 32'h7FFF_FFFF);
        send(REQ_LOAD_H, 6'd0, 6'd0, 32'h7FFF_FFFF);
        send(REQ_LOAD_H, 6'd0, 6'd1, 32'h8000_0000);
        send(REQ_LOAD_H, 6'd1, 6'd0, 32'h0000_0001);
        send(REQ_LOAD_H, 6'd1, 6'd1, 32'hFF00_0000);
        send(REQ_LOAD_CS, 6'h3F, 6'd0, 32'h8000_0000);
        send(REQ_LOAD_CS, 6'h00, 6'd1, 32'h7FFF_FFFF);
        send(REQ_SAMPLE, 6'd0, 6'd0, 32'h007F_FFFF);
        send(REQ_SAMPLE, 6'd0, 6'd5, 32'h1234_5678);
        send(REQ_SAMPLE, 6'h3F, 6'd1, 32'hFF80_0000);
        send(REQ_SAMPLE, 6'd0, 6'd0, 32'hFF80_0000);
        send(REQ_SAMPLE, 6'd0, 6'd1, 32'h7F80_0000);
        write_reg(CFG_INVERSE_SUM, 32'd0);
        send(REQ_SAMPLE, 6'd0, 6'd0, 32'h0000_0001);
        send(REQ_SAMPLE, 6'd0, 6'd1, 32'hFFFF_FFFF);
        write_reg(CFG_INVERSE_SUM, 32'h8000_0000);
        time_point(2, 0);
        write_reg(CFG_INVERSE_SUM, 32'h0000_0001);
        time_point(2, 0);

        while (accepted < 360 || sb.results_seen < 60)
        begin
            phases++;
            in_idle_pct = (phases % 5 == 2) ? 0 : 29;
            out_idle_pct = in_idle_pct;
            raw = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(7);
            if (clamp_n(raw) > 8) raw = $urandom_range(2, 6);
            n = clamp_n(raw);
            write_reg(CFG_CHANNEL_COUNT, raw);
            case ($urandom_range(5))
                0: write_reg(CFG_INVERSE_SUM, 32'd0);
                1: write_reg(CFG_INVERSE_SUM, $urandom);
                default: write_reg(CFG_INVERSE_SUM, rand_coef() | 32'h0000_0001);
            endcase
            if (n <= 8) load_region(n);
            repeat ($urandom_range(1, 3))
            begin
                time_point(n, 1);
                if ($urandom_range(3) == 0) drain();
            end
        end

        drain();
        $display("Run covered %0d input items, %0d time points and %0d Laplacian results,",
                 accepted, sb.points_done, sb.results_seen);
        $display("over %0d randomized channel-count and inverse-sum settings.", phases);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### filelist.f
hdl/sla_pkg.sv
hdl/sla_queue.sv
hdl/sla_front.sv
hdl/sla_div.sv
hdl/sla_back.sv
hdl/surface_laplacian_apply.sv
bench/tb_surface_laplacian_apply.sv
